@@ rtl/core/cbp_pkg.sv @@
package cbp_pkg;

  localparam int unsigned DimW    = 13;
  localparam int unsigned PitchW  = 17;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned PixW    = 32;
  localparam int unsigned OffW    = 28;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DimW-1:0]   FrameWidthRst   = DimW'(320);
  localparam logic [DimW-1:0]   FrameHeightRst  = DimW'(200);
  localparam logic [DimW-1:0]   ScreenWidthRst  = DimW'(640);
  localparam logic [DimW-1:0]   ScreenHeightRst = DimW'(480);
  localparam logic [PitchW-1:0] RowPitchRst     = PitchW'(2560);
  localparam logic [ShiftW-1:0] RedShiftRst     = ShiftW'(16);
  localparam logic [ShiftW-1:0] GreenShiftRst   = ShiftW'(8);
  localparam logic [ShiftW-1:0] BlueShiftRst    = ShiftW'(0);

  localparam int unsigned RedPos   = 16;
  localparam int unsigned GreenPos = 8;
  localparam int unsigned BluePos  = 0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth   = 3'd0,
    CfgFrameHeight  = 3'd1,
    CfgScreenWidth  = 3'd2,
    CfgScreenHeight = 3'd3,
    CfgRowPitch     = 3'd4,
    CfgRedShift     = 3'd5,
    CfgGreenShift   = 3'd6,
    CfgBlueShift    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0]   frame_width;
    logic [DimW-1:0]   frame_height;
    logic [DimW-1:0]   screen_width;
    logic [DimW-1:0]   screen_height;
    logic [PitchW-1:0] row_pitch;
    logic [ShiftW-1:0] red_shift;
    logic [ShiftW-1:0] green_shift;
    logic [ShiftW-1:0] blue_shift;
  } cfg_t;

  typedef struct packed {
    logic            visible;
    logic            frame_end;
    logic [DimW-1:0] dx;
    logic [DimW-1:0] dy;
    logic [PixW-1:0] pixel;
  } place_t;

endpackage

@@ rtl/core/cbp_place.sv @@
module cbp_place #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbp_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [31:0]     source_pixel_i,
  output logic            s1_valid_o,
  output cbp_pkg::place_t s1_data_o,
  input  logic            s1_take_i
);
  import cbp_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_DIM);
  localparam int unsigned FW  = $clog2(MAX_DIM + 1);
  localparam int unsigned EW  = (FW > DimW) ? FW : DimW;
  localparam int unsigned SW  = EW + 2;

  logic [CW-1:0]        col_q, col_d;
  logic [CW-1:0]        row_q, row_d;
  logic                 s1_valid_q, s1_valid_d;
  place_t               s1_q, s1_d;
  logic                 accept;
  logic [EW-1:0]        fw_raw, fh_raw, fw_c, fh_c;
  logic                 last_col, last_row;
  logic signed [SW-1:0] diff_x, diff_y, ox, oy, dx, dy, sw_s, sh_s;

  always_comb begin
    fw_raw = EW'(cfg_i.frame_width);
    fh_raw = EW'(cfg_i.frame_height);
    if (fw_raw == '0) begin
      fw_c = EW'(1);
    end else if (fw_raw > EW'(MAX_DIM)) begin
      fw_c = EW'(MAX_DIM);
    end else begin
      fw_c = fw_raw;
    end
    if (fh_raw == '0) begin
      fh_c = EW'(1);
    end else if (fh_raw > EW'(MAX_DIM)) begin
      fh_c = EW'(MAX_DIM);
    end else begin
      fh_c = fh_raw;
    end
    last_col = EW'(col_q) >= (fw_c - EW'(1));
    last_row = EW'(row_q) >= (fh_c - EW'(1));

    sw_s   = signed'(SW'(cfg_i.screen_width));
    sh_s   = signed'(SW'(cfg_i.screen_height));
    diff_x = sw_s - signed'(SW'(fw_c));
    diff_y = sh_s - signed'(SW'(fh_c));
    // Halving that rounds toward zero, as integer division does.
    ox     = (diff_x + signed'(SW'(diff_x[SW-1]))) >>> 1;
    oy     = (diff_y + signed'(SW'(diff_y[SW-1]))) >>> 1;
    dx     = ox + signed'(SW'(col_q));
    dy     = oy + signed'(SW'(row_q));
  end

  assign in_stall_o = s1_valid_q && !s1_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (s1_take_i) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d     = 1'b1;
      s1_d.visible   = !dx[SW-1] && (dx < sw_s) && !dy[SW-1] && (dy < sh_s);
      s1_d.frame_end = last_col && last_row;
      s1_d.dx        = dx[DimW-1:0];
      s1_d.dy        = dy[DimW-1:0];
      s1_d.pixel     = source_pixel_i;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_data_o  = s1_q;

endmodule

@@ rtl/core/cbp_pack.sv @@
module cbp_pack (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbp_pkg::cfg_t   cfg_i,
  input  logic            s1_valid_i,
  input  cbp_pkg::place_t s1_data_i,
  output logic            s1_take_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            write_enable_o,
  output logic [27:0]     byte_offset_o,
  output logic [31:0]     packed_pixel_o,
  output logic            frame_end_o
);
  import cbp_pkg::*;

  localparam int unsigned ProdW = DimW + PitchW;

  logic                   out_valid_q, out_valid_d;
  logic                   advance;
  logic [ProdW-1:0]       prod;
  logic [OffW-1:0]        offset;
  logic [PixW-1:0]        packed_w;
  logic [PixW-1:0]        red_w, green_w, blue_w;
  logic                   we_q, fe_q;
  logic [OffW-1:0]        off_q;
  logic [PixW-1:0]        pix_q;

  assign advance   = !out_valid_q || !out_stall_i;
  assign s1_take_o = advance && s1_valid_i;

  always_comb begin
    prod     = ProdW'(s1_data_i.dy) * ProdW'(cfg_i.row_pitch);
    offset   = prod[OffW-1:0] + OffW'({s1_data_i.dx, 2'b00});
    red_w    = PixW'(s1_data_i.pixel[RedPos +: ChanW]) << cfg_i.red_shift;
    green_w  = PixW'(s1_data_i.pixel[GreenPos +: ChanW]) << cfg_i.green_shift;
    blue_w   = PixW'(s1_data_i.pixel[BluePos +: ChanW]) << cfg_i.blue_shift;
    packed_w = red_w | green_w | blue_w;
    out_valid_d = advance ? s1_valid_i : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take_o) begin
      we_q  <= s1_data_i.visible;
      fe_q  <= s1_data_i.frame_end;
      off_q <= s1_data_i.visible ? offset : '0;
      pix_q <= s1_data_i.visible ? packed_w : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign byte_offset_o  = off_q;
  assign packed_pixel_o = pix_q;
  assign frame_end_o    = fe_q;

endmodule

@@ rtl/core/centered_clipped_pixel_blit.sv @@
// Centred, clipped pixel blit: source pixels enter one transaction at a time in
// row-major frame order on the input channel (in_valid_i, in_stall_o,
// source_pixel_i as 0x00RRGGBB). Each one yields exactly one result
// transaction on the output channel (out_valid_o, out_stall_i): a write
// enable that is low for clipped pixels, the screen byte offset, the pixel
// repacked by the configured channel shifts, and a flag on the last pixel.
// The block is two register stages deep: a result passes the placement register
// and then the result register before it is offered on the output, and one pixel
// is taken in every cycle for as long as the receiver keeps out_stall_i low. The
// placement stage and the result register each hold one transaction, so up to two
// transactions wait inside while the receiver stalls; once both stages are full,
// in_stall_o follows out_stall_i in the same cycle. Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i while the block is idle.
// Reset restores the default geometry of a 320 by 200 frame on a 640 by 480
// screen, clears the column and row counters and empties both stages.
module centered_clipped_pixel_blit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] source_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [27:0] byte_offset_o,
  output logic [31:0] packed_pixel_o,
  output logic        frame_end_o
);
  import cbp_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   s1_valid;
  place_t s1_data;
  logic   s1_take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFrameWidth:   cfg_d.frame_width   = cfg_wdata_i[DimW-1:0];
        CfgFrameHeight:  cfg_d.frame_height  = cfg_wdata_i[DimW-1:0];
        CfgScreenWidth:  cfg_d.screen_width  = cfg_wdata_i[DimW-1:0];
        CfgScreenHeight: cfg_d.screen_height = cfg_wdata_i[DimW-1:0];
        CfgRowPitch:     cfg_d.row_pitch     = cfg_wdata_i[PitchW-1:0];
        CfgRedShift:     cfg_d.red_shift     = cfg_wdata_i[ShiftW-1:0];
        CfgGreenShift:   cfg_d.green_shift   = cfg_wdata_i[ShiftW-1:0];
        CfgBlueShift:    cfg_d.blue_shift    = cfg_wdata_i[ShiftW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FrameWidthRst;
      cfg_q.frame_height  <= FrameHeightRst;
      cfg_q.screen_width  <= ScreenWidthRst;
      cfg_q.screen_height <= ScreenHeightRst;
      cfg_q.row_pitch     <= RowPitchRst;
      cfg_q.red_shift     <= RedShiftRst;
      cfg_q.green_shift   <= GreenShiftRst;
      cfg_q.blue_shift    <= BlueShiftRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cbp_place #(
    .MAX_DIM(MAX_DIM)
  ) u_place (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_pixel_i (source_pixel_i),
    .s1_valid_o     (s1_valid),
    .s1_data_o      (s1_data),
    .s1_take_i      (s1_take)
  );

  cbp_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .s1_valid_i     (s1_valid),
    .s1_data_i      (s1_data),
    .s1_take_o      (s1_take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .byte_offset_o  (byte_offset_o),
    .packed_pixel_o (packed_pixel_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

@@ bench/tb_centered_clipped_pixel_blit.sv @@
module tb_centered_clipped_pixel_blit;
  timeunit 1ns;
  timeprecision 1ps;

  import cbp_pkg::*;

  localparam int MaxDim     = 4096;
  localparam int IdlePct    = 28;
  localparam int HoldCycles = 200;
  localparam int CycleLimit = 100000;

  typedef struct packed {
    logic            write_enable;
    logic [OffW-1:0] byte_offset;
    logic [PixW-1:0] packed_pixel;
    logic            frame_end;
  } blit_write_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  cfg_idx_e          cfg_idx_i      = CfgFrameWidth;
  logic [CfgW-1:0]   cfg_wdata_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [PixW-1:0]   source_pixel_i = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic              write_enable_o;
  logic [OffW-1:0]   byte_offset_o;
  logic [PixW-1:0]   packed_pixel_o;
  logic              frame_end_o;

  cfg_t              geom;
  int                col_pos;
  int                row_pos;
  blit_write_t       pending_writes_q[$];
  logic [PixW-1:0]   pixel_feed_q[$];
  bit                steady      = 1'b0;
  int                hold_req    = 0;
  int                hold_seen;
  int                hold_left;
  int                errors      = 0;
  int                cycle_count = 0;

  centered_clipped_pixel_blit #(
    .MAX_DIM(MaxDim)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_pixel_i(source_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .write_enable_o(write_enable_o),
    .byte_offset_o (byte_offset_o),
    .packed_pixel_o(packed_pixel_o),
    .frame_end_o   (frame_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_extent(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  function automatic blit_write_t place_pixel(logic [PixW-1:0] pix);
    int          fw;
    int          fh;
    int          sw;
    int          sh;
    int          dx;
    int          dy;
    bit          last_c;
    bit          last_r;
    logic [63:0] off;
    logic [63:0] word;
    blit_write_t r;
    fw = clamp_extent(geom.frame_width);
    fh = clamp_extent(geom.frame_height);
    sw = int'(geom.screen_width);
    sh = int'(geom.screen_height);
    dx = (sw - fw) / 2 + col_pos;
    dy = (sh - fh) / 2 + row_pos;
    last_c = col_pos >= fw - 1;
    last_r = row_pos >= fh - 1;
    r = '0;
    r.write_enable = dx >= 0 && dx < sw && dy >= 0 && dy < sh;
    if (r.write_enable) begin
      off = 64'(dy) * 64'(geom.row_pitch) + 64'(dx) * 64'd4;
      word = (64'(pix[RedPos +: ChanW]) << geom.red_shift) |
             (64'(pix[GreenPos +: ChanW]) << geom.green_shift) |
             (64'(pix[BluePos +: ChanW]) << geom.blue_shift);
      r.byte_offset  = off[OffW-1:0];
      r.packed_pixel = word[PixW-1:0];
    end
    r.frame_end = last_c && last_r;
    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      source_pixel_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_writes_q.push_back(place_pixel(source_pixel_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_feed_q.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid_i     <= 1'b1;
          source_pixel_i <= pixel_feed_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    blit_write_t want;
    blit_write_t got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen   <= 0;
      hold_left   <= 0;
    end else begin
      // Each result transaction is checked against the oldest prediction.
      if (out_valid_o && !out_stall_i) begin
        got = {write_enable_o, byte_offset_o, packed_pixel_o, frame_end_o};
        if (pending_writes_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result at %0t: we=%0b off=%h pix=%h end=%0b",
                     $time, got.write_enable, got.byte_offset, got.packed_pixel,
                     got.frame_end);
          end
        end else begin
          want = pending_writes_q.pop_front();
          if (got.write_enable !== want.write_enable ||
              got.byte_offset !== want.byte_offset ||
              got.packed_pixel !== want.packed_pixel ||
              got.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: expected we=%0b off=%h pix=%h end=%0b",
                       $time, want.write_enable, want.byte_offset, want.packed_pixel,
                       want.frame_end);
              $display("                 actual   we=%0b off=%h pix=%h end=%0b",
                       got.write_enable, got.byte_offset, got.packed_pixel,
                       got.frame_end);
            end
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen   <= hold_req;
        hold_left   <= HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL centered_clipped_pixel_blit");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgFrameWidth:   geom.frame_width   = value[DimW-1:0];
      CfgFrameHeight:  geom.frame_height  = value[DimW-1:0];
      CfgScreenWidth:  geom.screen_width  = value[DimW-1:0];
      CfgScreenHeight: geom.screen_height = value[DimW-1:0];
      CfgRowPitch:     geom.row_pitch     = value[PitchW-1:0];
      CfgRedShift:     geom.red_shift     = value[ShiftW-1:0];
      CfgGreenShift:   geom.green_shift   = value[ShiftW-1:0];
      CfgBlueShift:    geom.blue_shift    = value[ShiftW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_geometry(int fw, int fh, int sw, int sh, int pitch,
                                  int rs, int gs, int bs);
    write_reg(CfgFrameWidth, CfgW'(fw));
    write_reg(CfgFrameHeight, CfgW'(fh));
    write_reg(CfgScreenWidth, CfgW'(sw));
    write_reg(CfgScreenHeight, CfgW'(sh));
    write_reg(CfgRowPitch, CfgW'(pitch));
    write_reg(CfgRedShift, CfgW'(rs));
    write_reg(CfgGreenShift, CfgW'(gs));
    write_reg(CfgBlueShift, CfgW'(bs));
  endtask

  task automatic program_random();
    if ($urandom_range(0, 3) == 0) begin
      program_geometry($urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 131071), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 31));
    end else begin
      program_geometry($urandom_range(1, 12), $urandom_range(1, 8),
                       $urandom_range(0, 16), $urandom_range(0, 12),
                       $urandom_range(4, 4096), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 31));
    end
  endtask

  task automatic drain();
    while (pixel_feed_q.size() != 0 || in_valid_i || pending_writes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int waited;
    geom = '{frame_width: FrameWidthRst, frame_height: FrameHeightRst,
             screen_width: ScreenWidthRst, screen_height: ScreenHeightRst,
             row_pitch: RowPitchRst, red_shift: RedShiftRst,
             green_shift: GreenShiftRst, blue_shift: BlueShiftRst};
    col_pos = 0;
    row_pos = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    pixel_feed_q = {32'h0000_0000, 32'hFFFF_FFFF, 32'h00A5_C33C};
    drain();

    program_geometry(4, 3, 1, 1, 4, 24, 24, 24);
    pixel_feed_q = {32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000,
                    32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'h0012_3456, 32'hA5A5_A5A5};
    drain();

    // Zero sizes: the frame saturates to one pixel and nothing reaches the screen.
    program_geometry(0, 0, 0, 0, 0, 0, 0, 0);
    pixel_feed_q = {32'hFFFF_FFFF, 32'h0080_4020};
    drain();

    // Oversized frame with the widest registers, so the offset overflows.
    program_geometry(8191, 1, 8191, 8191, 131071, 31, 31, 31);
    pixel_feed_q = {32'hFFFF_FFFF, 32'h0081_4201, 32'h0000_0000, 32'h00FF_FFFF};
    drain();

    // The column counter now lies beyond the narrower frame.
    program_geometry(2, 2, 3, 3, 12, 5, 13, 29);
    pixel_feed_q = {32'h00C3_3C99, 32'hFFFF_FFFF, 32'h0001_0101, 32'h00FE_FEFE};
    drain();

    for (int p = 0; p < 14; p++) begin
      program_random();
      if (p == 3) begin
        hold_req <= hold_req + 1;
      end
      steady <= (p == 6);
      repeat ($urandom_range(40, 60)) pixel_feed_q.push_back($urandom());
      drain();
    end

    waited = 0;
    while (pending_writes_q.size() != 0 && waited < 100) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    errors += pending_writes_q.size();
    if (errors == 0) begin
      $display("PASS centered_clipped_pixel_blit");
    end else begin
      $display("FAIL centered_clipped_pixel_blit");
    end
    $finish;
  end

endmodule

@@ centered_clipped_pixel_blit.f @@
rtl/core/cbp_pkg.sv
rtl/core/cbp_place.sv
rtl/core/cbp_pack.sv
rtl/core/centered_clipped_pixel_blit.sv
bench/tb_centered_clipped_pixel_blit.sv
